[sv/rhcm_pkg.sv]
package rhcm_pkg;

  localparam int PIX_W      = 16;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 9;
  localparam int QUO_W      = 16;
  localparam int DIV_STEPS  = QUO_W;
  localparam int OUT_DATA_W = 3 * CH_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int NUM_REGS   = 8;

  // Register map
  localparam logic [2:0] REG_HUE_LOW       = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH      = 3'd1;
  localparam logic [2:0] REG_HUE_WRAPS     = 3'd2;
  localparam logic [2:0] REG_SAT_LOW       = 3'd3;
  localparam logic [2:0] REG_SAT_HIGH      = 3'd4;
  localparam logic [2:0] REG_LUM_LOW       = 3'd5;
  localparam logic [2:0] REG_LUM_HIGH      = 3'd6;
  localparam logic [2:0] REG_TARGET_ENABLE = 3'd7;

  // Channel holding the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [CH_W-1:0]  HUE_BASE_RED_NEG = 8'd240;
  localparam logic [CH_W-1:0]  HUE_BASE_GREEN   = 8'd80;
  localparam logic [CH_W-1:0]  HUE_BASE_BLUE    = 8'd160;
  localparam logic [CH_W-1:0]  SCALE_MAX        = 8'd240;
  localparam logic [SUM_W-1:0] SAT_DEN_TOP      = 9'd480;
  // s2 at or below this gives luminance <= 120
  localparam logic [SUM_W-1:0] LUM_HALF_SUM     = 9'd257;
  // floor(s2 * 240 / 510) == (s2 * 30848) >> 16 for s2 <= 504
  localparam logic [14:0]      LUM_RECIP        = 15'd30848;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [1:0]      sel;
  } chan_t;

  typedef struct packed {
    logic [CH_W-1:0]  h_rem;
    logic [QUO_W-1:0] h_quo;
    logic [CH_W-1:0]  h_den;
    logic             h_neg;
    logic [CH_W-1:0]  h_base;
    logic             h_zero;
    logic [SUM_W-1:0] s_rem;
    logic [QUO_W-1:0] s_quo;
    logic [SUM_W-1:0] s_den;
    logic             s_zero;
    logic [CH_W-1:0]  lum;
  } div_item_t;

  // One restoring step for both quotients: shift in a numerator bit, try the subtract.
  function automatic div_item_t div_step(input div_item_t cur);
    div_item_t        nxt;
    logic [CH_W:0]    h_try;
    logic [SUM_W:0]   s_try;
    logic             h_bit;
    logic             s_bit;
    nxt   = cur;
    h_try = {cur.h_rem, cur.h_quo[QUO_W-1]};
    s_try = {cur.s_rem, cur.s_quo[QUO_W-1]};
    h_bit = (h_try >= {1'b0, cur.h_den});
    s_bit = (s_try >= {1'b0, cur.s_den});
    nxt.h_rem = h_bit ? CH_W'(h_try - {1'b0, cur.h_den}) : h_try[CH_W-1:0];
    nxt.s_rem = s_bit ? SUM_W'(s_try - {1'b0, cur.s_den}) : s_try[SUM_W-1:0];
    nxt.h_quo = {cur.h_quo[QUO_W-2:0], h_bit};
    nxt.s_quo = {cur.s_quo[QUO_W-2:0], s_bit};
    return nxt;
  endfunction

endpackage

[sv/rgb565_hsl_color_match_core.sv]
// Channel   Direction  Handshake                Payload
// s_*       in         s_tvalid / s_tready      s_tdata: pixel_rgb565
// m_*       out        m_tvalid / m_tready      m_tdata: hue, saturation, luminance; m_tuser: is_match
// cfg_*     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel per cycle sustained while the skid entry is free; results pass the stage 1 register,
// the operand register and the 16 one-bit restoring steps of the hue and saturation dividers.
// rst is synchronous and clears valid bits and all color-match registers.
// A 2-entry output skid register decouples m_tready; the pipeline stalls as a whole
// only when both entries are full, and s_tready is a registered signal.
// cfg_ready is always high; writes to an index of 8 or above are dropped.
module rgb565_hsl_color_match_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rhcm_pkg::PIX_W-1:0]          s_tdata,   // [15:0] pixel_rgb565
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rhcm_pkg::OUT_DATA_W-1:0]     m_tdata,   // [7:0] hue, [15:8] saturation,
                                                         // [23:16] luminance
  output logic                                m_tuser,   // [0] is_match
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rhcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rhcm_pkg::*;

  // Configuration registers
  logic [CH_W-1:0] hue_low, hue_high, sat_low, sat_high, lum_low, lum_high;
  logic            hue_wraps, target_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low       <= '0;
      hue_high      <= '0;
      hue_wraps     <= 1'b0;
      sat_low       <= '0;
      sat_high      <= '0;
      lum_low       <= '0;
      lum_high      <= '0;
      target_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      case (cfg_index[2:0])
        REG_HUE_LOW:       hue_low       <= cfg_data;
        REG_HUE_HIGH:      hue_high      <= cfg_data;
        REG_HUE_WRAPS:     hue_wraps     <= cfg_data[0];
        REG_SAT_LOW:       sat_low       <= cfg_data;
        REG_SAT_HIGH:      sat_high      <= cfg_data;
        REG_LUM_LOW:       lum_low       <= cfg_data;
        REG_LUM_HIGH:      lum_high      <= cfg_data;
        REG_TARGET_ENABLE: target_enable <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // Pipeline control: all stages move together while the skid entry is free
  logic adv;
  logic skid_valid;

  assign adv      = !skid_valid;
  assign s_tready = adv;

  // Stage 1: expand channels, find max and min
  chan_t           c1, c1_next;
  logic            v1;
  logic [CH_W-1:0] in_r, in_g, in_b;

  always_comb begin
    in_r = {s_tdata[15:11], 3'b000};
    in_g = {s_tdata[10:5], 2'b00};
    in_b = {s_tdata[4:0], 3'b000};
    c1_next.r  = in_r;
    c1_next.g  = in_g;
    c1_next.b  = in_b;
    c1_next.mx = in_r;
    c1_next.mn = in_r;
    if (in_g > c1_next.mx) c1_next.mx = in_g;
    if (in_b > c1_next.mx) c1_next.mx = in_b;
    if (in_g < c1_next.mn) c1_next.mn = in_g;
    if (in_b < c1_next.mn) c1_next.mn = in_b;
    if (in_r >= in_g && in_r >= in_b) begin
      c1_next.sel = SEL_RED;
    end else if (in_g >= in_b) begin
      c1_next.sel = SEL_GREEN;
    end else begin
      c1_next.sel = SEL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) c1 <= c1_next;
  end

  // Stage 2: differences, luminance, divider operands
  div_item_t         d0_next;
  logic [CH_W-1:0]   dd;
  logic [SUM_W-1:0]  s2;
  logic [CH_W:0]     hdiff;
  logic [CH_W-1:0]   hmag;
  logic [23:0]       lum_prod;

  always_comb begin
    dd = c1.mx - c1.mn;
    s2 = SUM_W'(c1.mx) + SUM_W'(c1.mn);
    case (c1.sel)
      SEL_RED:   hdiff = {1'b0, c1.g} - {1'b0, c1.b};
      SEL_GREEN: hdiff = {1'b0, c1.b} - {1'b0, c1.r};
      default:   hdiff = {1'b0, c1.r} - {1'b0, c1.g};
    endcase
    hmag     = hdiff[CH_W] ? CH_W'(-hdiff) : hdiff[CH_W-1:0];
    lum_prod = 24'(s2) * 24'(LUM_RECIP);

    d0_next.h_rem  = '0;
    d0_next.h_quo  = (QUO_W'(hmag) << 5) + (QUO_W'(hmag) << 3);
    d0_next.h_den  = dd;
    d0_next.h_neg  = hdiff[CH_W];
    d0_next.h_zero = (dd == '0);
    case (c1.sel)
      SEL_RED:   d0_next.h_base = hdiff[CH_W] ? HUE_BASE_RED_NEG : '0;
      SEL_GREEN: d0_next.h_base = HUE_BASE_GREEN;
      default:   d0_next.h_base = HUE_BASE_BLUE;
    endcase

    d0_next.s_rem = '0;
    d0_next.s_quo = (QUO_W'(dd) << 8) - (QUO_W'(dd) << 4);
    if (s2 <= LUM_HALF_SUM) begin
      d0_next.s_den  = s2;
      d0_next.s_zero = (dd == '0);
    end else begin
      // Non-positive denominator clamps to zero
      d0_next.s_den  = SAT_DEN_TOP - s2;
      d0_next.s_zero = (dd == '0) || (s2 >= SAT_DEN_TOP);
    end
    // Peaks at 235, no clamp needed
    d0_next.lum = lum_prod[23:16];
  end

  div_item_t pipe [0:DIV_STEPS];
  logic      vld  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= v1;
      for (int k = 0; k < DIV_STEPS; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= d0_next;
      for (int k = 0; k < DIV_STEPS; k++) pipe[k+1] <= div_step(pipe[k]);
    end
  end

  // Final: assemble hue, clamp saturation, range checks
  div_item_t               fin;
  logic [CH_W-1:0]         hue_v, sat_v, lum_v;
  logic                    hue_ok, match_v;
  logic [OUT_DATA_W-1:0]   res_data;

  always_comb begin
    fin = pipe[DIV_STEPS];
    if (fin.h_zero) begin
      hue_v = '0;
    end else if (fin.h_neg) begin
      hue_v = fin.h_base - fin.h_quo[CH_W-1:0];
    end else begin
      hue_v = fin.h_base + fin.h_quo[CH_W-1:0];
    end
    if (fin.s_zero) begin
      sat_v = '0;
    end else if ((fin.s_quo[QUO_W-1:CH_W] != '0) || (fin.s_quo[CH_W-1:0] > SCALE_MAX)) begin
      sat_v = SCALE_MAX;
    end else begin
      sat_v = fin.s_quo[CH_W-1:0];
    end
    lum_v = fin.lum;
    if (hue_wraps) begin
      hue_ok = (hue_v >= hue_low) || (hue_v <= hue_high);
    end else begin
      hue_ok = (hue_v >= hue_low) && (hue_v <= hue_high);
    end
    match_v = target_enable && hue_ok &&
              (sat_v >= sat_low) && (sat_v <= sat_high) &&
              (lum_v >= lum_low) && (lum_v <= lum_high);
    res_data = {lum_v, sat_v, hue_v};
  end

  // Output register with skid entry
  logic                  push, pop;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  skid_match;

  assign push = adv && vld[DIV_STEPS];
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_tdata <= skid_data;
        m_tuser <= skid_match;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tdata <= res_data;
        m_tuser <= match_v;
      end else begin
        skid_data  <= res_data;
        skid_match <= match_v;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry holds a result while the output register is empty");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (rst)
    (!adv && vld[DIV_STEPS]) |=> (vld[DIV_STEPS] && $stable(pipe[DIV_STEPS])))
    else $error("last pipeline stage changed during a stall");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:0] <= SCALE_MAX) && (m_tdata[15:8] <= SCALE_MAX) &&
                  (m_tdata[23:16] <= SCALE_MAX)))
    else $error("hue, saturation or luminance above 240");

  a_disabled_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !target_enable) |-> !m_tuser)
    else $error("match reported while matching is disabled");
`endif

endmodule
